### rtl/mmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mmc_pkg;

  localparam int unsigned NumAxes = 3;
  localparam int unsigned AxisW   = 16;
  localparam int unsigned ScaleW  = 32;
  localparam int unsigned LimitW  = 15;
  localparam int unsigned CountW  = 16;
  localparam int unsigned QuoW    = 27;

  localparam logic signed [AxisW-1:0] MinStart   = 16'sd32764;
  localparam logic signed [AxisW-1:0] MaxStart   = -16'sd32763;
  localparam logic [ScaleW-1:0]       ScaleOne   = 32'h0001_0000;
  localparam logic [ScaleW-1:0]       ScaleSat   = 32'hFFFF_FFFF;
  localparam logic [QuoW-1:0]         ScaleNumer = 27'd131072000;
  localparam logic [LimitW-1:0]       LimitReset = 15'd600;

  typedef logic signed [AxisW-1:0] axis_t;
  typedef logic [ScaleW-1:0]       scale_t;

  typedef struct packed {
    logic             start;
    logic [AxisW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [QuoW-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

### rtl/mmc_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module mmc_mul import mmc_pkg::*; (
  input  wire    clk_i,
  input  axis_t  raw_i,
  input  axis_t  off_i,
  input  scale_t scale_i,
  output axis_t  corr_o
);

  logic signed [AxisW:0]  diff;
  logic [AxisW:0]         mag;
  logic                   neg;
  logic [AxisW+ScaleW:0]  prod;
  logic [ScaleW:0]        quo_q;
  logic                   neg_q;

  always_comb begin
    diff = {raw_i[AxisW-1], raw_i} - {off_i[AxisW-1], off_i};
    neg  = diff[AxisW];
    mag  = neg ? ((AxisW+1)'(0) - diff) : diff;
    prod = (AxisW+ScaleW+1)'(mag) * (AxisW+ScaleW+1)'(scale_i);
  end

  // register the product before saturation
  always_ff @(posedge clk_i) begin
    quo_q <= prod[AxisW+ScaleW:16];
    neg_q <= neg;
  end

  always_comb begin
    if (neg_q) begin
      if (quo_q > (ScaleW+1)'(32768)) corr_o = -16'sd32768;
      else                            corr_o = AxisW'((ScaleW+1)'(0) - quo_q);
    end else begin
      if (quo_q > (ScaleW+1)'(32767)) corr_o = 16'sd32767;
      else                            corr_o = quo_q[AxisW-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/mmc_div.sv
`timescale 1ns / 1ps
`default_nettype none

module mmc_div import mmc_pkg::*; (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic             run_q;
  logic             done_q;
  logic [4:0]       cnt_q;
  logic [AxisW-1:0] den_q;
  logic [AxisW-1:0] rem_q;
  logic [QuoW-1:0]  num_q;
  logic [AxisW:0]   trial;
  logic             fits;

  always_comb begin
    trial = {rem_q, num_q[QuoW-1]};
    fits  = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(QuoW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, shifted into the numerator register
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q <= req_i.divisor;
      rem_q <= '0;
      num_q <= ScaleNumer;
    end else if (run_q) begin
      rem_q <= fits ? AxisW'(trial - {1'b0, den_q}) : trial[AxisW-1:0];
      num_q <= {num_q[QuoW-2:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = num_q;

endmodule

`default_nettype wire

### rtl/magnetometer_minmax_calibration.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake                   Payload
// in        in         in_valid_i / in_ready_o     action, raw_x/y/z
// out       out        out_valid_o / out_ready_i   corrected, flags, offsets, scales
// cfg       in         cfg_we_i                    cfg_wdata_i (cal_sample_limit)
//
// A sample result is offered once one shared multiplier has corrected the
// three axes in turn, each in the StMul and StSat states. The finishing
// sample then passes StFin for each axis and also StDiv for each axis with a
// nonzero span (bit-serial divider, one quotient bit a cycle). A start result
// is offered in StOut, entered straight from StIdle. Reset is asynchronous
// and active low; no clearing pass is needed. A stalled result holds the
// block; no new transaction is taken until it leaves.

module magnetometer_minmax_calibration import mmc_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire               action_i,
  input  axis_t             raw_x_i,
  input  axis_t             raw_y_i,
  input  axis_t             raw_z_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output axis_t             corrected_x_o,
  output axis_t             corrected_y_o,
  output axis_t             corrected_z_o,
  output logic              cal_busy_o,
  output logic              cal_done_o,
  output logic              start_accepted_o,
  output axis_t             offset_x_o,
  output axis_t             offset_y_o,
  output axis_t             offset_z_o,
  output scale_t            scale_x_o,
  output scale_t            scale_y_o,
  output scale_t            scale_z_o,
  input  wire               cfg_we_i,
  input  wire  [LimitW-1:0] cfg_wdata_i
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StSat  = 3'd2;
  localparam logic [2:0] StFin  = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  localparam logic [1:0] LastAxis = 2'(NumAxes - 1);

  logic [2:0]        state_q, state_d;
  logic [1:0]        axis_q, axis_d;
  logic              action_q;
  axis_t             raw_q   [NumAxes];
  axis_t             min_q   [NumAxes];
  axis_t             max_q   [NumAxes];
  axis_t             off_q   [NumAxes];
  scale_t            scale_q [NumAxes];
  axis_t             corr_q  [NumAxes];
  logic [CountW-1:0] cnt_q;
  logic [CountW-1:0] cnt_inc;
  logic              busy_q;
  logic              done_q;
  logic              acc_q;
  logic [LimitW-1:0] limit_q;

  logic              in_fire;
  logic              last;
  logic signed [AxisW:0] diff_s;
  logic [AxisW-1:0]  diff_u;
  axis_t             corr;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign in_fire = in_valid_i && in_ready_o;
  assign last    = axis_q == LastAxis;
  assign cnt_inc = cnt_q + CountW'(1);

  always_comb begin
    diff_s = {max_q[axis_q][AxisW-1], max_q[axis_q]} - {min_q[axis_q][AxisW-1], min_q[axis_q]};
    diff_u = diff_s[AxisW] ? '0 : diff_s[AxisW-1:0];
  end

  mmc_mul u_mul (
    .clk_i   (clk_i),
    .raw_i   (raw_q[axis_q]),
    .off_i   (off_q[axis_q]),
    .scale_i (scale_q[axis_q]),
    .corr_o  (corr)
  );

  assign div_req.start   = (state_q == StFin) && (diff_u != '0);
  assign div_req.divisor = diff_u;

  mmc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          axis_d  = '0;
          state_d = action_i ? StOut : StMul;
        end
      end
      StMul: state_d = StSat;
      StSat: begin
        if (!last) begin
          axis_d  = axis_q + 2'd1;
          state_d = StMul;
        end else if (busy_q && (cnt_inc > {1'b0, limit_q})) begin
          axis_d  = '0;
          state_d = StFin;
        end else begin
          state_d = StOut;
        end
      end
      StFin: begin
        if (diff_u != '0) begin
          state_d = StDiv;
        end else if (last) begin
          state_d = StOut;
        end else begin
          axis_d = axis_q + 2'd1;
        end
      end
      StDiv: begin
        if (div_rsp.done) begin
          if (last) begin
            state_d = StOut;
          end else begin
            axis_d  = axis_q + 2'd1;
            state_d = StFin;
          end
        end
      end
      StOut: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      axis_q  <= '0;
      cnt_q   <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      acc_q   <= 1'b0;
      limit_q <= LimitReset;
      for (int i = 0; i < NumAxes; i++) begin
        min_q[i]   <= MinStart;
        max_q[i]   <= MaxStart;
        off_q[i]   <= '0;
        scale_q[i] <= ScaleOne;
      end
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            done_q <= 1'b0;
            acc_q  <= action_i && !busy_q;
            if (action_i && !busy_q) begin
              busy_q <= 1'b1;
              cnt_q  <= '0;
              for (int i = 0; i < NumAxes; i++) begin
                min_q[i] <= MinStart;
                max_q[i] <= MaxStart;
              end
            end
          end
        end
        StSat: begin
          if (busy_q) begin
            if (raw_q[axis_q] < min_q[axis_q]) min_q[axis_q] <= raw_q[axis_q];
            if (raw_q[axis_q] > max_q[axis_q]) max_q[axis_q] <= raw_q[axis_q];
            if (last) cnt_q <= cnt_inc;
          end
        end
        StFin: begin
          off_q[axis_q] <= AxisW'(max_q[axis_q] - axis_t'({1'b0, diff_u[AxisW-1:1]}));
          if (diff_u == '0) begin
            scale_q[axis_q] <= ScaleSat;
            if (last) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end
          end
        end
        StDiv: begin
          if (div_rsp.done) begin
            scale_q[axis_q] <= ScaleW'(div_rsp.quotient);
            if (last) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      action_q <= action_i;
      raw_q[0] <= raw_x_i;
      raw_q[1] <= raw_y_i;
      raw_q[2] <= raw_z_i;
      for (int i = 0; i < NumAxes; i++) corr_q[i] <= '0;
    end else if (state_q == StSat && !action_q) begin
      corr_q[axis_q] <= corr;
    end
  end

  assign in_ready_o       = state_q == StIdle;
  assign out_valid_o      = state_q == StOut;
  assign corrected_x_o    = corr_q[0];
  assign corrected_y_o    = corr_q[1];
  assign corrected_z_o    = corr_q[2];
  assign cal_busy_o       = busy_q;
  assign cal_done_o       = done_q;
  assign start_accepted_o = acc_q;
  assign offset_x_o       = off_q[0];
  assign offset_y_o       = off_q[1];
  assign offset_z_o       = off_q[2];
  assign scale_x_o        = scale_q[0];
  assign scale_y_o        = scale_q[1];
  assign scale_z_o        = scale_q[2];

endmodule

`default_nettype wire

### rtl/mmc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mmc_checker import mmc_pkg::*; (
  input wire    clk_i,
  input wire    rst_ni,
  input wire    in_ready_o,
  input wire    out_valid_o,
  input wire    out_ready_i,
  input axis_t  corrected_x_o,
  input axis_t  corrected_y_o,
  input axis_t  corrected_z_o,
  input wire    cal_busy_o,
  input wire    cal_done_o,
  input wire    start_accepted_o,
  input scale_t scale_x_o
);

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  a_return_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> in_ready_o)
    else $error("not ready after result transaction");

  a_start_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && start_accepted_o |-> cal_busy_o && !cal_done_o &&
      corrected_x_o == 16'sd0 && corrected_y_o == 16'sd0 && corrected_z_o == 16'sd0)
    else $error("start result inconsistent");

  a_done_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cal_done_o |-> !cal_busy_o && !start_accepted_o)
    else $error("done result inconsistent");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(corrected_x_o) &&
      $stable(scale_x_o))
    else $error("stalled result changed");

endmodule

bind magnetometer_minmax_calibration mmc_checker u_mmc_checker (.*);

`default_nettype wire
